@@ rtl/regular_polygon_vertex_gen_macros.svh @@
// Assertion macros for the regular polygon vertex generator.
`ifndef REGULAR_POLYGON_VERTEX_GEN_MACROS_SVH
`define REGULAR_POLYGON_VERTEX_GEN_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(name, ante, cons, msg)
`define ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

@@ rtl/rpvg_pkg.sv @@
// Constants, angle table and output placement for the polygon vertex generator.
`default_nettype none

package rpvg_pkg;

    localparam int MAX_SIDES     = 64;
    localparam int CORDIC_STEPS  = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int CORDIC_ITERS  = (CORDIC_STEPS < ANG_TABLE_LEN) ? CORDIC_STEPS
                                                                  : ANG_TABLE_LEN;
    localparam int ITER_W        = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
    localparam int ANG_IDX_W     = $clog2(ANG_TABLE_LEN);

    localparam int COORD_W   = 24;
    localparam int RADIUS_W  = 23;
    localparam int SIDES_W   = 7;
    localparam int VERTEX_W  = 25;
    localparam int VIDX_W    = 6;
    localparam int PHASE_W   = 32;
    localparam int PROD_W    = 56;
    localparam int DIV_CNT_W = 6;
    localparam int DIV_TOP   = 32;

    localparam logic signed [PHASE_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032875;
    localparam logic [SIDES_W-1:0] SIDES_MAX = SIDES_W'(MAX_SIDES);

    function automatic logic signed [PHASE_W-1:0] atan_phase(
        input logic [ANG_IDX_W-1:0] idx
    );
        logic signed [PHASE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sh20000000;
            5'd1:    v = 32'sh12E4051E;
            5'd2:    v = 32'sh09FB385B;
            5'd3:    v = 32'sh051111D4;
            5'd4:    v = 32'sh028B0D43;
            5'd5:    v = 32'sh0145D7E1;
            5'd6:    v = 32'sh00A2F61E;
            5'd7:    v = 32'sh00517C55;
            5'd8:    v = 32'sh0028BE53;
            5'd9:    v = 32'sh00145F2F;
            5'd10:   v = 32'sh000A2F98;
            5'd11:   v = 32'sh000517CC;
            5'd12:   v = 32'sh00028BE6;
            5'd13:   v = 32'sh000145F3;
            5'd14:   v = 32'sh0000A2FA;
            5'd15:   v = 32'sh0000517D;
            5'd16:   v = 32'sh000028BE;
            5'd17:   v = 32'sh0000145F;
            5'd18:   v = 32'sh00000A30;
            5'd19:   v = 32'sh00000518;
            5'd20:   v = 32'sh0000028C;
            5'd21:   v = 32'sh00000146;
            5'd22:   v = 32'sh000000A3;
            5'd23:   v = 32'sh00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VERTEX_W-1:0] place(
        input logic signed [COORD_W-1:0] centre,
        input logic signed [PROD_W-1:0]  prod
    );
        logic signed [PROD_W-1:0]   rnd;
        logic signed [VERTEX_W+1:0] sum;
        logic [VERTEX_W-1:0]        res;
        rnd = prod + (PROD_W'(1) <<< 29);
        sum = {rnd[PROD_W-1], rnd[PROD_W-1:30]}
            + {{(VERTEX_W+2-COORD_W){centre[COORD_W-1]}}, centre};
        if (sum > $signed((VERTEX_W+2)'(27'sd16777215)))
        begin
            res = {1'b0, {(VERTEX_W-1){1'b1}}};
        end
        else if (sum < -$signed((VERTEX_W+2)'(27'sd16777216)))
        begin
            res = {1'b1, {(VERTEX_W-1){1'b0}}};
        end
        else
        begin
            res = sum[VERTEX_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/regular_polygon_vertex_gen.sv @@
// Regular polygon vertex generator: divider, shared CORDIC rotator and output placement.
//
// Input stream s_axis carries one polygon: centre, radius and side count.
// Output stream m_axis carries one transfer per vertex, tlast on the final one.
// Side counts above 64 are clamped to 64; a count of zero produces no output.
// After an input transfer the block first forms the angle step 2^32/n in a
// bit-serial divider, then for each vertex runs a 16-step CORDIC rotation on
// one shared add/shift unit, two multiplies on one shared multiplier and
// rounding/saturation, and shows the vertex.
// s_axis_tready is high only while idle; one polygon is handled at a time.
// When the receiver stalls, the vertex holds in the output registers and the
// block waits. Reset returns the block to idle with no output pending.
`default_nettype none
`include "regular_polygon_vertex_gen_macros.svh"

module regular_polygon_vertex_gen
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // center_x, center_y, radius, sides, 2'b0
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // vertex_x, vertex_y, vertex_index
    output logic             m_axis_tlast
);

    typedef enum logic [6:0]
    {
        ST_IDLE   = 7'b0000001,
        ST_DIV    = 7'b0000010,
        ST_SETUP  = 7'b0000100,
        ST_CORDIC = 7'b0001000,
        ST_MUL_X  = 7'b0010000,
        ST_MUL_Y  = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    localparam int PW = rpvg_pkg::PHASE_W;
    localparam int SW = rpvg_pkg::SIDES_W;

    state_t                               state_reg, state_next;
    logic [rpvg_pkg::DIV_CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [SW-1:0]                        n_reg, n_next;
    logic [SW-1:0]                        rem_reg, rem_next;
    logic [SW-1:0]                        frac_reg, frac_next;
    logic [PW-1:0]                        q_reg, q_next;
    logic [PW-1:0]                        phase_reg, phase_next;
    logic [rpvg_pkg::VIDX_W-1:0]          idx_reg, idx_next;
    logic [rpvg_pkg::ITER_W-1:0]          k_reg, k_next;
    logic                                 flip_reg, flip_next;
    logic                                 fin_reg, fin_next;

    logic signed [rpvg_pkg::COORD_W-1:0]  cx_reg, cx_next;
    logic signed [rpvg_pkg::COORD_W-1:0]  cy_reg, cy_next;
    logic [rpvg_pkg::RADIUS_W-1:0]        r_reg, r_next;
    logic signed [PW-1:0]                 x_reg, x_next;
    logic signed [PW-1:0]                 y_reg, y_next;
    logic signed [PW-1:0]                 z_reg, z_next;
    logic signed [rpvg_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [rpvg_pkg::VERTEX_W-1:0]        vx_reg, vx_next;
    logic [rpvg_pkg::VERTEX_W-1:0]        vy_reg, vy_next;

    logic [SW-1:0]                        sides_in;
    logic [SW:0]                          rem_shift;
    logic                                 rem_ge;
    logic [SW:0]                          frac_sum;
    logic                                 frac_carry;
    logic signed [PW-1:0]                 dx, dy, ang;
    logic signed [PW-1:0]                 mul_op;
    logic signed [rpvg_pkg::RADIUS_W:0]   r_op;
    logic signed [rpvg_pkg::PROD_W-1:0]   mul_res;
    logic signed [rpvg_pkg::COORD_W-1:0]  place_centre;
    logic [rpvg_pkg::VERTEX_W-1:0]        place_res;
    logic                                 last;

    assign sides_in  = s_axis_tdata[77:71];
    assign rem_shift = {rem_reg, div_cnt_reg == rpvg_pkg::DIV_CNT_W'(rpvg_pkg::DIV_TOP)};
    assign rem_ge    = rem_shift >= {1'b0, n_reg};
    assign frac_sum  = {1'b0, frac_reg} + {1'b0, rem_reg};
    assign frac_carry = frac_sum >= {1'b0, n_reg};

    assign dx  = y_reg >>> k_reg;
    assign dy  = x_reg >>> k_reg;
    assign ang = rpvg_pkg::atan_phase(rpvg_pkg::ANG_IDX_W'(k_reg));

    assign r_op    = $signed({1'b0, r_reg});
    assign mul_op  = (state_reg == ST_MUL_X) ? (flip_reg ? -y_reg : y_reg)
                                             : (flip_reg ? -x_reg : x_reg);
    assign mul_res = rpvg_pkg::PROD_W'(r_op) * rpvg_pkg::PROD_W'(mul_op);

    assign place_centre = fin_reg ? cy_reg : cx_reg;
    assign place_res    = rpvg_pkg::place(place_centre, prod_reg);

    assign last = {1'b0, idx_reg} == (n_reg - SW'(1));

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = state_reg == ST_OUT;
    assign m_axis_tdata  = {idx_reg, vy_reg, vx_reg};
    assign m_axis_tlast  = last;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        n_next       = n_reg;
        rem_next     = rem_reg;
        frac_next    = frac_reg;
        q_next       = q_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        flip_next    = flip_reg;
        fin_next     = fin_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        r_next       = r_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        prod_next    = prod_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cx_next      = s_axis_tdata[23:0];
                    cy_next      = s_axis_tdata[47:24];
                    r_next       = s_axis_tdata[70:48];
                    n_next       = (sides_in > rpvg_pkg::SIDES_MAX) ? rpvg_pkg::SIDES_MAX
                                                                    : sides_in;
                    div_cnt_next = rpvg_pkg::DIV_CNT_W'(rpvg_pkg::DIV_TOP);
                    rem_next     = '0;
                    q_next       = '0;
                    frac_next    = '0;
                    phase_next   = '0;
                    idx_next     = '0;
                    if (sides_in != '0)
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? SW'(rem_shift - {1'b0, n_reg}) : rem_shift[SW-1:0];
                q_next   = {q_reg[PW-2:0], rem_ge};
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - rpvg_pkg::DIV_CNT_W'(1);
                end
            end
            ST_SETUP:
            begin
                x_next     = rpvg_pkg::CORDIC_GAIN_Q30;
                y_next     = '0;
                z_next     = {phase_reg[30], phase_reg[30:0]};
                flip_next  = phase_reg[31] ^ phase_reg[30];
                k_next     = '0;
                fin_next   = 1'b0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (!z_reg[PW-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - ang;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + ang;
                end
                if (k_reg == rpvg_pkg::ITER_W'(rpvg_pkg::CORDIC_ITERS - 1))
                begin
                    state_next = ST_MUL_X;
                end
                else
                begin
                    k_next = k_reg + rpvg_pkg::ITER_W'(1);
                end
            end
            ST_MUL_X:
            begin
                prod_next  = mul_res;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                if (!fin_reg)
                begin
                    vx_next   = place_res;
                    prod_next = mul_res;
                    fin_next  = 1'b1;
                end
                else
                begin
                    vy_next    = place_res;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        frac_next  = frac_carry ? SW'(frac_sum - {1'b0, n_reg})
                                                : frac_sum[SW-1:0];
                        phase_next = phase_reg + q_reg + {{(PW-1){1'b0}}, frac_carry};
                        idx_next   = idx_reg + rpvg_pkg::VIDX_W'(1);
                        state_next = ST_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            n_reg       <= '0;
            rem_reg     <= '0;
            frac_reg    <= '0;
            q_reg       <= '0;
            phase_reg   <= '0;
            idx_reg     <= '0;
            k_reg       <= '0;
            flip_reg    <= 1'b0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            n_reg       <= n_next;
            rem_reg     <= rem_next;
            frac_reg    <= frac_next;
            q_reg       <= q_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            k_reg       <= k_next;
            flip_reg    <= flip_next;
            fin_reg     <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        r_reg    <= r_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        prod_reg <= prod_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
    end

    `ASSERT_IMPLY(a_ready_valid_excl, s_axis_tready, !m_axis_tvalid, "ready while output valid")
    `ASSERT_NEXT(a_last_to_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        s_axis_tready, "no return to idle after last vertex")
    `ASSERT_NEXT(a_index_advance, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        idx_reg == $past(idx_reg) + rpvg_pkg::VIDX_W'(1), "vertex index did not advance")
    `ASSERT_IMPLY(a_frac_bound, state_reg == ST_CORDIC,
        (frac_reg < n_reg) && (rem_reg < n_reg), "phase remainder out of range")

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the regular polygon vertex generator with a per-vertex predictor.
module tb_top;

    localparam int     IDLE_PCT        = 34;
    localparam int     HOLD_OFF_CYCLES = 600;
    localparam int     WATCHDOG_LIMIT  = 4000;
    localparam int     SETTLE_CYCLES   = 200;
    localparam int     PRINT_LIMIT     = 30;
    localparam int     VX_LSB          = 0;
    localparam int     VY_LSB          = rpvg_pkg::VERTEX_W;
    localparam int     IDX_LSB         = 2 * rpvg_pkg::VERTEX_W;
    localparam longint VERTEX_HI       = 64'sd16777215;
    localparam longint VERTEX_LO       = -64'sd16777216;
    localparam longint FULL_TURN       = 64'sh1_0000_0000;

    localparam logic signed [rpvg_pkg::COORD_W-1:0] COORD_HI =
        {1'b0, {(rpvg_pkg::COORD_W-1){1'b1}}};
    localparam logic signed [rpvg_pkg::COORD_W-1:0] COORD_LO =
        {1'b1, {(rpvg_pkg::COORD_W-1){1'b0}}};
    localparam logic [rpvg_pkg::RADIUS_W-1:0]       RADIUS_TOP = '1;

    typedef struct packed {
        logic signed [rpvg_pkg::COORD_W-1:0] cx;
        logic signed [rpvg_pkg::COORD_W-1:0] cy;
        logic [rpvg_pkg::RADIUS_W-1:0]       r;
        logic [rpvg_pkg::SIDES_W-1:0]        n;
    } polygon_t;

    typedef struct packed {
        logic [rpvg_pkg::VERTEX_W-1:0] vx;
        logic [rpvg_pkg::VERTEX_W-1:0] vy;
        logic [rpvg_pkg::VIDX_W-1:0]   idx;
        logic                          last;
    } vertex_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [79:0] s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    vertex_t expected_vertices[$];
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    int      hold_left    = 0;
    bit      hold_request = 1'b0;
    bit      no_idle      = 1'b0;

    regular_polygon_vertex_gen i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic longint arc_angle(input int k);
        case (k)
            0:       return 64'h20000000;
            1:       return 64'h12E4051E;
            2:       return 64'h09FB385B;
            3:       return 64'h051111D4;
            4:       return 64'h028B0D43;
            5:       return 64'h0145D7E1;
            6:       return 64'h00A2F61E;
            7:       return 64'h00517C55;
            8:       return 64'h0028BE53;
            9:       return 64'h00145F2F;
            10:      return 64'h000A2F98;
            11:      return 64'h000517CC;
            12:      return 64'h00028BE6;
            13:      return 64'h000145F3;
            14:      return 64'h0000A2FA;
            15:      return 64'h0000517D;
            16:      return 64'h000028BE;
            17:      return 64'h0000145F;
            18:      return 64'h00000A30;
            19:      return 64'h00000518;
            20:      return 64'h0000028C;
            21:      return 64'h00000146;
            22:      return 64'h000000A3;
            default: return 64'h00000051;
        endcase
    endfunction

    function automatic void unit_vector(input longint unsigned phase, output longint sin_q30,
                                        output longint cos_q30);
        longint unsigned p;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        bit              flip;
        p    = phase;
        flip = 1'b0;
        x    = longint'(rpvg_pkg::CORDIC_GAIN_Q30);
        y    = 0;
        // fold into the quarter turn around zero
        if (p >= 64'h4000_0000 && p < 64'hC000_0000)
        begin
            p    = (p - 64'h8000_0000) & 64'hFFFF_FFFF;
            flip = 1'b1;
        end
        z = (p >= 64'h8000_0000) ? longint'(p) - FULL_TURN : longint'(p);
        for (int k = 0; k < rpvg_pkg::CORDIC_STEPS && k < 24; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arc_angle(k);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arc_angle(k);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sin_q30 = y;
        cos_q30 = x;
    endfunction

    function automatic logic [rpvg_pkg::VERTEX_W-1:0] vertex_coord(
        input longint centre,
        input longint r,
        input longint unit_q30
    );
        longint v;
        v = centre + ((r * unit_q30 + (64'sd1 <<< 29)) >>> 30);
        if (v > VERTEX_HI)
            v = VERTEX_HI;
        if (v < VERTEX_LO)
            v = VERTEX_LO;
        return v[rpvg_pkg::VERTEX_W-1:0];
    endfunction

    function automatic void predict_polygon(input polygon_t p);
        longint unsigned n;
        longint unsigned phase;
        longint          s;
        longint          c;
        longint          cx;
        longint          cy;
        longint          r;
        vertex_t         v;
        cx = longint'($signed(p.cx));
        cy = longint'($signed(p.cy));
        r  = longint'(p.r);
        n  = p.n;
        if (n > rpvg_pkg::MAX_SIDES)
            n = rpvg_pkg::MAX_SIDES;
        for (longint unsigned i = 0; i < n; i++)
        begin
            phase = ((i << 32) / n) & 64'hFFFF_FFFF;
            unit_vector(phase, s, c);
            v.vx   = vertex_coord(cx, r, s);
            v.vy   = vertex_coord(cy, r, c);
            v.idx  = i[rpvg_pkg::VIDX_W-1:0];
            v.last = (i + 1 == n);
            expected_vertices.push_back(v);
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    task automatic check_vertex();
        vertex_t want;
        if (expected_vertices.size() == 0)
        begin
            report_mismatch("unexpected vertex", m_axis_tdata, 0);
            return;
        end
        want = expected_vertices.pop_front();
        if (m_axis_tdata[VX_LSB +: rpvg_pkg::VERTEX_W] !== want.vx)
            report_mismatch("vertex_x", m_axis_tdata[VX_LSB +: rpvg_pkg::VERTEX_W], want.vx);
        if (m_axis_tdata[VY_LSB +: rpvg_pkg::VERTEX_W] !== want.vy)
            report_mismatch("vertex_y", m_axis_tdata[VY_LSB +: rpvg_pkg::VERTEX_W], want.vy);
        if (m_axis_tdata[IDX_LSB +: rpvg_pkg::VIDX_W] !== want.idx)
            report_mismatch("vertex_index", m_axis_tdata[IDX_LSB +: rpvg_pkg::VIDX_W],
                            want.idx);
        if (m_axis_tlast !== want.last)
            report_mismatch("last_vertex", m_axis_tlast, want.last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_vertex();
    end

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_polygon(input polygon_t p);
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tdata  <= {2'b00, p.n, p.r, p.cy, p.cx};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        predict_polygon(p);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_vertices.size() != 0);
    endtask

    function automatic polygon_t make_polygon(input logic signed [rpvg_pkg::COORD_W-1:0] cx,
                                              input logic signed [rpvg_pkg::COORD_W-1:0] cy,
                                              input logic [rpvg_pkg::RADIUS_W-1:0] r,
                                              input logic [rpvg_pkg::SIDES_W-1:0] n);
        polygon_t p;
        p.cx = cx;
        p.cy = cy;
        p.r  = r;
        p.n  = n;
        return p;
    endfunction

    function automatic polygon_t random_polygon();
        polygon_t p;
        int       roll;
        roll = $urandom_range(99);
        // keep most polygons small, some larger, a few empty or clamped
        if (roll < 4)
            p.n = '0;
        else if (roll < 8)
            p.n = rpvg_pkg::SIDES_W'($urandom_range(65, 127));
        else if (roll < 20)
            p.n = rpvg_pkg::SIDES_W'($urandom_range(9, 64));
        else
            p.n = rpvg_pkg::SIDES_W'($urandom_range(1, 8));
        case ($urandom_range(3))
            0:       p.r = rpvg_pkg::RADIUS_W'($urandom_range(4095));
            1:       p.r = RADIUS_TOP - rpvg_pkg::RADIUS_W'($urandom_range(4095));
            default: p.r = rpvg_pkg::RADIUS_W'($urandom);
        endcase
        p.cx = rpvg_pkg::COORD_W'($urandom);
        p.cy = rpvg_pkg::COORD_W'($urandom);
        if ($urandom_range(9) == 0)
            p.cx = $urandom_range(1) ? COORD_HI : COORD_LO;
        if ($urandom_range(9) == 0)
            p.cy = $urandom_range(1) ? COORD_HI : COORD_LO;
        return p;
    endfunction

    task automatic test_directed_shapes();
        send_polygon(make_polygon(0, 0, 256, 1));
        send_polygon(make_polygon(0, 0, 256, 2));
        send_polygon(make_polygon(0, 0, 256, 3));
        send_polygon(make_polygon(0, 0, 256, 4));
        send_polygon(make_polygon(0, 0, 256, 0));
        send_polygon(make_polygon(100, -100, 0, 5));
        send_polygon(make_polygon(COORD_HI, COORD_HI, RADIUS_TOP, 4));
        send_polygon(make_polygon(COORD_LO, COORD_LO, RADIUS_TOP, 4));
        send_polygon(make_polygon(COORD_HI, COORD_LO, RADIUS_TOP, 8));
        send_polygon(make_polygon(0, 0, RADIUS_TOP, 64));
        send_polygon(make_polygon(-1, -1, RADIUS_TOP, 127));
        send_polygon(make_polygon(COORD_HI, COORD_LO, 1, 65));
        send_polygon(make_polygon(24'sh555555, 24'shAAAAAA, 23'h2AAAAA, 6));
        send_polygon(make_polygon(24'shAAAAAA, 24'sh555555, 23'h555555, 7));
        send_polygon(make_polygon(COORD_LO, COORD_HI, RADIUS_TOP, 0));
        send_polygon(make_polygon(0, 0, RADIUS_TOP, 12));
    endtask

    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        repeat (count) send_polygon(random_polygon());
        no_idle = 1'b0;
    endtask

    task automatic test_random_idling(input int count);
        repeat (count) send_polygon(random_polygon());
    endtask

    // hold the receiver off while polygons keep coming
    task automatic test_output_stall(input int count);
        hold_request = 1'b1;
        repeat (count) send_polygon(random_polygon());
    endtask

    task automatic test_drain_pause(input int count);
        wait_drained();
        repeat (count) send_polygon(random_polygon());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_shapes();
        test_back_to_back(50);
        test_random_idling(220);
        test_output_stall(30);
        test_drain_pause(40);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
